@@ rtl/bpo_pkg.sv @@
// ---------------------------------------------------------------------------
// bpo_pkg
// shared types, codes and constants of the band-limited pulse oscillator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpo_pkg;

	// input beat kinds
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// register addresses
	localparam logic [15:0] ADDR_DUTY     = 16'h4000;
	localparam logic [15:0] ADDR_TIMER_LO = 16'h4002;
	localparam logic [15:0] ADDR_TIMER_HI = 16'h4003;

	// default parameter values
	localparam int HARMONICS_DEF   = 19;
	localparam int TICK_DIVIDE_DEF = 6;

	// arithmetic constants
	localparam int CLOCK_RATIO = 48;
	localparam int CUBIC_GAIN  = 21284;   // 20.785 in q.10
	localparam int TWO_OVER_PI = 41722;   // 2/pi in q0.16

	localparam logic [32:0] PHASE_ONE = 33'h1_0000_0000;
	localparam logic [31:0] INC_RESET = 32'(PHASE_ONE / 33'(CLOCK_RATIO));

	// shared divider widths
	localparam int DIV_NUM_W = 33;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_CNT_W = 6;

	// cubic result width, q.28 signed
	localparam int CUB_W = 32;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

	// duty as a q0.32 phase offset
	function automatic logic [31:0] duty_phase(input logic [1:0] code);
		logic [31:0] d;
		d = {code, 30'b0};
		if (code == 2'd0) begin
			d = 32'h2000_0000;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

@@ rtl/bpo_divider.sv @@
// ---------------------------------------------------------------------------
// bpo_divider
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpo_divider
	import bpo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule
`default_nettype wire

@@ rtl/bpo_cubic.sv @@
// ---------------------------------------------------------------------------
// bpo_cubic
// four-stage pipeline for 20.785 * f * (f - 1/2) * (f - 1), q.28 result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpo_cubic
	import bpo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [15:0]        frac,
	output logic                    out_valid,
	output logic signed [CUB_W-1:0] cubic
);

	logic signed [17:0] fa;
	logic signed [17:0] fb;
	logic signed [17:0] fc;
	logic signed [35:0] prod1;
	logic signed [53:0] prod2;
	logic signed [64:0] prod3;
	logic signed [63:0] rnd;
	logic signed [63:0] shifted;

	logic signed [35:0] p1_s1;
	logic signed [17:0] c_s1;
	logic signed [48:0] p2_s2;
	logic signed [63:0] p3_s3;
	logic [3:0]         vld_q;

	assign fa      = $signed({2'b00, frac});
	assign fb      = fa - 18'sd32768;
	assign fc      = fa - 18'sd65536;
	assign prod1   = fa * fb;
	assign prod2   = p1_s1 * c_s1;
	assign prod3   = p2_s2 * $signed(16'(CUBIC_GAIN));
	assign rnd     = p3_s3 + 64'sh2000_0000;
	assign shifted = rnd >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		p1_s1 <= prod1;
		c_s1  <= fc;
		p2_s2 <= prod2[48:0];
		p3_s3 <= prod3[63:0];
		cubic <= shifted[CUB_W-1:0];
	end

	assign out_valid = vld_q[3];

endmodule
`default_nettype wire

@@ rtl/bandlimited_pulse_oscillator.sv @@
// ---------------------------------------------------------------------------
// bandlimited_pulse_oscillator
// one band-limited pulse channel: register writes and clock ticks in,
// held q4.12 sample out once per tick
// ---------------------------------------------------------------------------
// A write beat (op 0) updates the duty code or the 11-bit timer and then
// recomputes the phase increment 2^32 / (48 * (timer + 1)) on the shared
// divider, with no result beat. A tick beat (op 1) advances the
// q0.32 phase. On the first tick after reset and every TICK_DIVIDE-th tick
// after it, the sample is rebuilt as 2/pi times the sum over HARMONICS
// harmonics of the difference of two cubic saws divided by the harmonic
// number. Each harmonic runs both cubics through one shared four-stage
// multiplier pipeline and then the shared 33-step divider. The block
// holds in_stall high while it works; a finished sample waits in the
// output register, and writes are still taken while it waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bandlimited_pulse_oscillator
	import bpo_pkg::*;
#(
	parameter int HARMONICS   = HARMONICS_DEF,
	parameter int TICK_DIVIDE = TICK_DIVIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [15:0] sample
);

	localparam int N_W    = $clog2(HARMONICS + 1);
	localparam int SUM_W  = 31 + N_W;
	localparam int PROD_W = SUM_W + 18;

	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'h8000_0000);
	localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] SAT_LO   = -SAT_HI - 1;

	// sequencer states
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_INC_START = 4'd1;
	localparam logic [3:0] ST_INC_WAIT  = 4'd2;
	localparam logic [3:0] ST_CA        = 4'd3;
	localparam logic [3:0] ST_CA_WAIT   = 4'd4;
	localparam logic [3:0] ST_CB        = 4'd5;
	localparam logic [3:0] ST_CB_WAIT   = 4'd6;
	localparam logic [3:0] ST_DIV_WAIT  = 4'd7;
	localparam logic [3:0] ST_SCALE1    = 4'd8;
	localparam logic [3:0] ST_SCALE2    = 4'd9;
	localparam logic [3:0] ST_EMIT      = 4'd10;

	logic [3:0]  state_q;

	// channel registers
	logic [10:0] timer_q;
	logic [1:0]  duty_q;
	logic [31:0] inc_q;
	logic [31:0] phase_q;
	logic [2:0]  pre_q;
	logic signed [15:0] held_q;

	// per-sample working registers
	logic [31:0]             shift_q;   // phase minus duty
	logic [31:0]             xa_q;      // n * phase, wrapped
	logic [31:0]             xb_q;      // n * shifted, wrapped
	logic [N_W-1:0]          n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [CUB_W-1:0] ca_q;
	logic                    neg_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic        in_acc;
	logic        emit_go;
	logic [31:0] phase_next;
	logic [3:0]  pre_inc;
	logic [11:0] timer_p1;
	logic [16:0] den;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                    cub_in_valid;
	logic [15:0]             cub_frac;
	logic                    cub_valid;
	logic signed [CUB_W-1:0] cub_out;

	logic signed [CUB_W:0]    diff;
	logic [CUB_W:0]           diff_mag;
	logic signed [SUM_W-1:0]  quot_s;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] scaled;
	logic signed [15:0]       sat;

	assign in_stall   = state_q != ST_IDLE;
	assign in_acc     = in_valid && !in_stall;
	assign phase_next = phase_q + inc_q;
	assign pre_inc    = {1'b0, pre_q} + 4'd1;

	// output register free or being drained this cycle
	assign emit_go = (state_q == ST_EMIT) && (!out_valid || !out_stall);

	// divider operands: increment update or one harmonic term
	assign timer_p1 = {1'b0, timer_q} + 12'd1;
	assign den      = 17'(CLOCK_RATIO) * {5'b0, timer_p1};

	assign diff     = {ca_q[CUB_W-1], ca_q} - {cub_out[CUB_W-1], cub_out};
	assign diff_mag = diff[CUB_W] ? (~diff + 1'b1) : diff;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = PHASE_ONE;
		div_req.divisor  = den;
		if (state_q == ST_INC_START) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_CB_WAIT) begin
			div_req.start    = cub_valid;
			div_req.dividend = diff_mag[DIV_NUM_W-1:0];
			div_req.divisor  = DIV_DEN_W'(n_q);
		end
	end

	// cubic feed, top 16 bits of the wrapped phase
	assign cub_in_valid = (state_q == ST_CA) || (state_q == ST_CB);
	assign cub_frac     = (state_q == ST_CB) ? xb_q[31:16] : xa_q[31:16];

	// term truncated toward zero, sign restored
	assign quot_s = neg_q ? -$signed(SUM_W'(div_rsp.quotient))
	                      : $signed(SUM_W'(div_rsp.quotient));

	// final scale by 2/pi, round half up, saturate
	assign prod   = sum_q * $signed({2'b00, 16'(TWO_OVER_PI)});
	assign rnd    = prod_s1 + HALF_LSB;
	assign scaled = rnd >>> 32;

	always_comb begin
		sat = scaled[15:0];
		if (scaled > SAT_HI) begin
			sat = 16'sh7fff;
		end else if (scaled < SAT_LO) begin
			sat = -16'sh8000;
		end
	end

	bpo_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bpo_cubic u_cubic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cub_in_valid),
		.frac      (cub_frac),
		.out_valid (cub_valid),
		.cubic     (cub_out)
	);

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			timer_q   <= '0;
			duty_q    <= '0;
			inc_q     <= INC_RESET;
			phase_q   <= '0;
			pre_q     <= '0;
			held_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == OP_WRITE) begin
							if (address == ADDR_DUTY) begin
								duty_q <= data[7:6];
							end else if (address == ADDR_TIMER_LO) begin
								timer_q[7:0] <= data;
							end else if (address == ADDR_TIMER_HI) begin
								timer_q[10:8] <= data[2:0];
							end
							state_q <= ST_INC_START;
						end else begin
							phase_q <= phase_next;
							pre_q   <= (pre_inc >= 4'(TICK_DIVIDE)) ? 3'd0 : pre_inc[2:0];
							state_q <= (pre_q == 3'd0) ? ST_CA : ST_EMIT;
						end
					end
				end
				ST_INC_START: begin
					state_q <= ST_INC_WAIT;
				end
				ST_INC_WAIT: begin
					if (div_rsp.done) begin
						inc_q   <= div_rsp.quotient[31:0];
						state_q <= ST_IDLE;
					end
				end
				ST_CA: begin
					state_q <= ST_CA_WAIT;
				end
				ST_CA_WAIT: begin
					if (cub_valid) begin
						state_q <= ST_CB;
					end
				end
				ST_CB: begin
					state_q <= ST_CB_WAIT;
				end
				ST_CB_WAIT: begin
					if (cub_valid) begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						state_q <= (n_q == N_W'(HARMONICS)) ? ST_SCALE1 : ST_CA;
					end
				end
				ST_SCALE1: begin
					state_q <= ST_SCALE2;
				end
				ST_SCALE2: begin
					held_q  <= sat;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the harmonic loop
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && op == OP_TICK) begin
			shift_q <= phase_next - duty_phase(duty_q);
			xa_q    <= phase_next;
			xb_q    <= phase_next - duty_phase(duty_q);
			n_q     <= N_W'(1);
			sum_q   <= '0;
		end
		if (state_q == ST_CA_WAIT && cub_valid) begin
			ca_q <= cub_out;
		end
		if (state_q == ST_CB_WAIT && cub_valid) begin
			neg_q <= diff[CUB_W];
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			sum_q <= sum_q + quot_s;
			n_q   <= n_q + 1'b1;
			xa_q  <= xa_q + phase_q;
			xb_q  <= xb_q + shift_q;
		end
		if (state_q == ST_SCALE1) begin
			prod_s1 <= prod;
		end
		if (emit_go) begin
			sample <= held_q;
		end
	end

endmodule
`default_nettype wire

@@ verif/bpo_sample_checker.sv @@
// ---------------------------------------------------------------------------
// bpo_sample_checker
// watches the one channel of the pulse oscillator, predicts each tick's sample
// and compares it with the sample the block hands out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpo_sample_checker
	import bpo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic               op,
	input  wire logic [15:0]        address,
	input  wire logic [7:0]         data,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [15:0] sample,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	logic [10:0]        timer_q;
	logic [1:0]         duty_q;
	logic [31:0]        step_q;
	logic [31:0]        phase_q;
	int                 presc_q;
	logic signed [15:0] held_q;
	logic signed [15:0] sample_fifo[$];

	function automatic logic [31:0] phase_step(input logic [10:0] tp);
		longint unsigned den;
		den = 64'd48 * (64'(tp) + 64'd1);
		return 32'((64'd1 << 32) / den);
	endfunction

	// cubic saw of a wrapped phase, q.28
	function automatic longint cubic_q28(input logic [31:0] x);
		longint f;
		longint t;
		f = longint'(x[31:16]);
		t = f * (f - 32768) * (f - 65536);
		return (t * 21284 + (longint'(1) <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [15:0] rebuild_sample(input logic [31:0] ph,
		input logic [1:0] code);
		logic [31:0] d;
		logic [31:0] sh;
		longint      sum;
		longint      v;
		d = (code == 2'd0) ? 32'h2000_0000 : {code, 30'b0};
		sh = ph - d;
		sum = 0;
		for (int n = 1; n <= HARMONICS_DEF; n++) begin
			sum += (cubic_q28(32'(ph * n)) - cubic_q28(32'(sh * n))) / longint'(n);
		end
		v = (sum * 41722 + (longint'(1) <<< 31)) >>> 32;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q = '0;
			duty_q  = '0;
			step_q  = phase_step(11'd0);
			phase_q = '0;
			presc_q = 0;
			held_q  = '0;
			sample_fifo.delete();
			errors  = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (sample_fifo.size() == 0) begin
					report($sformatf("sample %0d with none expected", sample));
				end else begin
					if (sample !== sample_fifo[0])
						report($sformatf("sample %0d, expected %0d", sample, sample_fifo[0]));
					void'(sample_fifo.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				if (op == OP_WRITE) begin
					if (address == ADDR_DUTY)
						duty_q = data[7:6];
					else if (address == ADDR_TIMER_LO)
						timer_q[7:0] = data;
					else if (address == ADDR_TIMER_HI)
						timer_q[10:8] = data[2:0];
					step_q = phase_step(timer_q);
				end else begin
					phase_q = phase_q + step_q;
					if (presc_q == 0)
						held_q = rebuild_sample(phase_q, duty_q);
					presc_q = (presc_q + 1 >= TICK_DIVIDE_DEF) ? 0 : presc_q + 1;
					sample_fifo.push_back(held_q);
				end
			end
			pending = sample_fifo.size();
		end
	end

endmodule

@@ verif/tb_bandlimited_pulse_oscillator.sv @@
// ---------------------------------------------------------------------------
// tb_bandlimited_pulse_oscillator
// drives register writes and ticks into the pulse oscillator with random gaps
// and stalls; a checker beside the block predicts every sample beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_bandlimited_pulse_oscillator;
	import bpo_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               op;
	logic [15:0]        address;
	logic [7:0]         data;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] sample;
	int                 errors;
	int                 pending;
	int                 checked;
	int                 n_writes;
	int                 n_ticks;
	int                 idle_cycles = 0;
	bit                 no_gaps;

	bandlimited_pulse_oscillator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .address(address), .data(data),
		.out_valid(out_valid), .out_stall(out_stall), .sample(sample)
	);

	bpo_sample_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .address(address), .data(data),
		.out_valid(out_valid), .out_stall(out_stall), .sample(sample),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// offer one beat and hold it until taken, then maybe drop valid for a gap
	task automatic send(input logic kind, input logic [15:0] addr, input logic [7:0] dat);
		int gap;
		in_valid <= 1'b1;
		op       <= kind;
		address  <= addr;
		data     <= dat;
		do @(posedge clk); while (in_stall);
		if (kind == OP_TICK) n_ticks++; else n_writes++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_beat();
		logic [15:0] addr;
		int r;
		r = $urandom_range(0, 99);
		if (r < 78) begin
			send(OP_TICK, 16'($urandom), 8'($urandom));
		end else begin
			case ($urandom_range(0, 3))
				0: addr = ADDR_DUTY;
				1: addr = ADDR_TIMER_LO;
				2: addr = ADDR_TIMER_HI;
				default: addr = 16'($urandom);
			endcase
			// keep the timer mostly small so the phase sweeps quickly
			if (addr == ADDR_TIMER_HI && $urandom_range(0, 3) != 0)
				send(OP_WRITE, addr, {5'($urandom), 3'd0});
			else
				send(OP_WRITE, addr, 8'($urandom));
		end
	endtask

	// receiver: random stalls, runs without stalls, and one long hold-off
	initial begin
		int k;
		out_stall <= 1'b0;
		@(posedge arst_n);
		for (k = 0; ; k++) begin
			if (k == 60) begin
				// long hold-off while the sender keeps offering beats
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ((k % 40 < 8) ? 200 : $urandom_range(1, 20)) @(posedge clk);
			if (k % 40 >= 8) begin
				out_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("timeout: no beat accepted for %0d cycles", idle_cycles);
			$display("FAIL bandlimited_pulse_oscillator");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n      = 1'b0;
		in_valid    <= 1'b0;
		op          <= OP_TICK;
		address     <= '0;
		data        <= '0;
		n_writes    = 0;
		n_ticks     = 0;
		no_gaps     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: reset state, every duty code, timer extremes, ignored writes
		send(OP_TICK, 16'h0000, 8'h00);
		send(OP_TICK, 16'hffff, 8'hff);
		send(OP_WRITE, ADDR_DUTY, 8'h40);
		send(OP_TICK, 16'h0000, 8'h00);
		send(OP_WRITE, ADDR_DUTY, 8'h80);
		send(OP_TICK, 16'h0000, 8'h00);
		send(OP_WRITE, ADDR_DUTY, 8'hff);
		send(OP_TICK, 16'h0000, 8'h00);
		send(OP_WRITE, ADDR_DUTY, 8'h3f);   // unused bits only, duty back to 1/8
		send(OP_WRITE, ADDR_TIMER_LO, 8'hff);
		send(OP_WRITE, ADDR_TIMER_HI, 8'hff);  // upper bits ignored, timer at max
		send(OP_TICK, 16'h0000, 8'h00);
		send(OP_WRITE, 16'h4001, 8'hff);     // other addresses leave state alone
		send(OP_WRITE, 16'hffff, 8'hff);
		send(OP_WRITE, 16'h0000, 8'h00);
		send(OP_TICK, 16'h0000, 8'h00);
		send(OP_WRITE, ADDR_TIMER_HI, 8'hf8);
		send(OP_WRITE, ADDR_TIMER_LO, 8'h00);  // timer back to zero
		for (i = 0; i < 5; i++) send(OP_TICK, 16'h0000, 8'h00);

		// random part, with a burst without gaps and one full drain
		for (i = 0; i < 1330; i++) begin
			no_gaps = (i >= 200 && i < 300);
			if (i == 700) begin
				in_valid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			random_beat();
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d register writes and %0d ticks, %0d samples compared",
			n_writes, n_ticks, checked);
		if (errors == 0)
			$display("PASS bandlimited_pulse_oscillator");
		else
			$display("FAIL bandlimited_pulse_oscillator");
		$finish;
	end

endmodule
